@@ sv/integer_alu_with_warnings_core_assert.svh @@
// Assertion macros for the ALU core
`ifndef INTEGER_ALU_WITH_WARNINGS_CORE_ASSERT_SVH
`define INTEGER_ALU_WITH_WARNINGS_CORE_ASSERT_SVH
`define IAW_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define IAW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ sv/iaw_pkg.sv @@
`timescale 1ns / 1ps
package iaw_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FUNC_W = 5;
    localparam int STATUS_W = 3;
    localparam int SHIFT_W = 5;
    localparam int SHIFT_LIMIT = 32;

    localparam logic [FUNC_W-1:0] FN_ADD = 5'd0;
    localparam logic [FUNC_W-1:0] FN_AND = 5'd1;
    localparam logic [FUNC_W-1:0] FN_LAND = 5'd2;
    localparam logic [FUNC_W-1:0] FN_OR = 5'd3;
    localparam logic [FUNC_W-1:0] FN_LOR = 5'd4;
    localparam logic [FUNC_W-1:0] FN_XOR = 5'd5;
    localparam logic [FUNC_W-1:0] FN_SUB = 5'd6;
    localparam logic [FUNC_W-1:0] FN_MUL = 5'd7;
    localparam logic [FUNC_W-1:0] FN_SHL = 5'd8;
    localparam logic [FUNC_W-1:0] FN_SAR = 5'd9;
    localparam logic [FUNC_W-1:0] FN_DIV = 5'd10;
    localparam logic [FUNC_W-1:0] FN_LT = 5'd11;
    localparam logic [FUNC_W-1:0] FN_GT = 5'd12;
    localparam logic [FUNC_W-1:0] FN_EQ = 5'd13;
    localparam logic [FUNC_W-1:0] FN_NE = 5'd14;
    localparam logic [FUNC_W-1:0] FN_LE = 5'd15;
    localparam logic [FUNC_W-1:0] FN_GE = 5'd16;

    localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHIFT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

    // side info for a divider op: divide flag, quotient sign and status; no module in the project uses it
    typedef struct packed {
        logic                 is_div;
        logic                 q_neg;
        logic [STATUS_W-1:0]  status;
    } div_tag_t;
endpackage

@@ sv/integer_alu_with_warnings_core.sv @@
`timescale 1ns / 1ps
// Every op takes the same path through the same register chain, whose depth is set
// by the one-bit-per-stage divider.
// Throughput: one word per cycle; the whole pipe stalls when the output is held.
// Reset: aresetn (synchronous, active low) clears all valid bits.
module integer_alu_with_warnings_core #(
    parameter int DATA_WIDTH = iaw_pkg::DATA_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [4:0] func, [DW+4:5] operand_a, [2DW+4:DW+5] operand_b, zero pad
    input  logic [((2*DATA_WIDTH+5+7)/8)*8-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [DW-1:0] result, [DW+2:DW] status, zero pad
    output logic [((DATA_WIDTH+3+7)/8)*8-1:0] m_tdata
);
    localparam int N = DATA_WIDTH;
    localparam int D = N + 2;
    localparam int OW = ((N + 3 + 7) / 8) * 8;

    localparam logic [1:0] SEL_SIMPLE = 2'd0;
    localparam logic [1:0] SEL_MUL = 2'd1;
    localparam logic [1:0] SEL_DIV = 2'd2;

    logic adv;
    logic [iaw_pkg::FUNC_W-1:0] func;
    logic [N-1:0] a, b, s_res, prod, quot;
    logic [iaw_pkg::STATUS_W-1:0] s_st;

    assign func = s_tdata[iaw_pkg::FUNC_W-1:0];
    assign a = s_tdata[N+4:5];
    assign b = s_tdata[2*N+4:N+5];

    logic [D-1:0] vld_reg, vld_next;
    logic [N-1:0] sres_reg [D];
    logic [iaw_pkg::STATUS_W-1:0] st_reg [D];
    logic [1:0] sel_reg [D];

    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    iaw_simple #(.DATA_WIDTH(N)) u_simple (
        .func(func), .a(a), .b(b), .res(s_res), .status(s_st)
    );
    iaw_mul #(.DATA_WIDTH(N)) u_mul (
        .aclk(aclk), .adv(adv), .a(a), .b(b), .prod(prod)
    );
    iaw_div #(.DATA_WIDTH(N)) u_div (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .a(a), .b(b), .quot(quot)
    );

    logic [1:0] sel_in;
    always_comb begin
        sel_in = SEL_SIMPLE;
        if (func == iaw_pkg::FN_MUL) sel_in = SEL_MUL;
        else if (func == iaw_pkg::FN_DIV && s_st == iaw_pkg::ST_OK) sel_in = SEL_DIV;
        vld_next = {vld_reg[D-2:0], s_tvalid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sres_reg[0] <= s_res;
            st_reg[0] <= s_st;
            sel_reg[0] <= sel_in;
            for (int i = 1; i < D; i++) begin
                sres_reg[i] <= sres_reg[i-1];
                st_reg[i] <= st_reg[i-1];
                sel_reg[i] <= sel_reg[i-1];
            end
        end
    end

    // register the mul product and carry it down the rest of the line
    logic [N-1:0] mres_reg [D-1];
    always_ff @(posedge aclk) begin
        if (adv) begin
            mres_reg[0] <= prod;
            for (int i = 1; i < D - 1; i++) begin
                mres_reg[i] <= mres_reg[i-1];
            end
        end
    end

    // divider output aligns with stage D-2; register the final pick
    logic [N-1:0] out_res_reg, out_res_next;
    logic [iaw_pkg::STATUS_W-1:0] out_st_reg;
    logic out_v_reg;
    always_comb begin
        case (sel_reg[D-2])
            SEL_MUL: out_res_next = mres_reg[D-3];
            SEL_DIV: out_res_next = quot;
            default: out_res_next = sres_reg[D-2];
        endcase
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= vld_reg[D-2];
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_res_reg <= out_res_next;
            out_st_reg <= st_reg[D-2];
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = OW'({out_st_reg, out_res_reg});

    logic unused_tail;
    assign unused_tail = vld_reg[D-1] ^ (|sres_reg[D-1]) ^ (|st_reg[D-1])
                       ^ (|sel_reg[D-1]) ^ (|mres_reg[D-2]);

    `include "integer_alu_with_warnings_core_assert.svh"
    `IAW_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "output word changed under stall")
    `IAW_ASSERT_IMPL(a_ready, aclk, aresetn, m_tvalid && !m_tready,
        !s_tready, "input taken while output stalled")
    `IAW_ASSERT_NEXT(a_flow, aclk, aresetn, s_tready && vld_reg[D-2],
        m_tvalid, "word lost at output stage")
endmodule

@@ sv/iaw_simple.sv @@
`timescale 1ns / 1ps
// Combinational ops: add, sub, logic, compare, shifts, invalid code, div corner flags
module iaw_simple #(
    parameter int DATA_WIDTH = iaw_pkg::DATA_WIDTH_DEF
) (
    input  logic [iaw_pkg::FUNC_W-1:0]   func,
    input  logic [DATA_WIDTH-1:0]        a,
    input  logic [DATA_WIDTH-1:0]        b,
    output logic [DATA_WIDTH-1:0]        res,
    output logic [iaw_pkg::STATUS_W-1:0] status
);
    localparam int AW = (DATA_WIDTH > 32) ? DATA_WIDTH : 33;
    logic signed [DATA_WIDTH-1:0] sa, sb;
    logic [iaw_pkg::SHIFT_W-1:0] amt;
    logic lt, gt, eqv, b_big;
    logic [AW-1:0] bx;
    logic [DATA_WIDTH-1:0] minv;

    always_comb begin
        sa = a;
        sb = b;
        lt = sa < sb;
        gt = sb < sa;
        eqv = a == b;
        amt = b[iaw_pkg::SHIFT_W-1:0];
        bx = AW'(b);
        b_big = bx >= AW'(iaw_pkg::SHIFT_LIMIT);
        minv = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        res = '0;
        status = iaw_pkg::ST_OK;
        case (func)
            iaw_pkg::FN_ADD: res = a + b;
            iaw_pkg::FN_AND: res = a & b;
            iaw_pkg::FN_LAND: res = DATA_WIDTH'((|a) && (|b));
            iaw_pkg::FN_OR: res = a | b;
            iaw_pkg::FN_LOR: res = DATA_WIDTH'((|a) || (|b));
            iaw_pkg::FN_XOR: res = a ^ b;
            iaw_pkg::FN_SUB: res = a - b;
            iaw_pkg::FN_MUL: res = '0;
            iaw_pkg::FN_SHL: begin
                res = (32'(amt) >= DATA_WIDTH) ? '0 : (a << amt);
                if (b_big) status = iaw_pkg::ST_SHIFT;
            end
            iaw_pkg::FN_SAR: begin
                res = (32'(amt) >= DATA_WIDTH) ? {DATA_WIDTH{a[DATA_WIDTH-1]}}
                                               : DATA_WIDTH'(sa >>> amt);
                if (b_big) status = iaw_pkg::ST_SHIFT;
            end
            iaw_pkg::FN_DIV: begin
                if (b == '0) begin
                    res = ~minv;
                    status = iaw_pkg::ST_DIVZERO;
                end else if (a == minv && (&b)) begin
                    res = minv;
                    status = iaw_pkg::ST_OVERFLOW;
                end
            end
            iaw_pkg::FN_LT: res = DATA_WIDTH'(lt);
            iaw_pkg::FN_GT: res = DATA_WIDTH'(gt);
            iaw_pkg::FN_EQ: res = DATA_WIDTH'(eqv);
            iaw_pkg::FN_NE: res = DATA_WIDTH'(!eqv);
            iaw_pkg::FN_LE: res = DATA_WIDTH'(!gt);
            iaw_pkg::FN_GE: res = DATA_WIDTH'(!lt);
            default: status = iaw_pkg::ST_INVALID;
        endcase
    end
endmodule

@@ sv/iaw_mul.sv @@
`timescale 1ns / 1ps
// Wrapping multiply in two stages: half-width partial products, then sum
module iaw_mul #(
    parameter int DATA_WIDTH = iaw_pkg::DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  adv,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic [DATA_WIDTH-1:0] prod
);
    localparam int HL = (DATA_WIDTH + 1) / 2;
    logic [2*HL-1:0] ll_reg, ll_next;
    logic [DATA_WIDTH-1:0] x1_reg, x1_next, x2_reg, x2_next;

    always_comb begin
        ll_next = (2*HL)'(a[HL-1:0]) * (2*HL)'(b[HL-1:0]);
        x1_next = DATA_WIDTH'(a[HL-1:0]) * DATA_WIDTH'(b[DATA_WIDTH-1:HL]);
        x2_next = DATA_WIDTH'(a[DATA_WIDTH-1:HL]) * DATA_WIDTH'(b[HL-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ll_reg <= ll_next;
            x1_reg <= x1_next;
            x2_reg <= x2_next;
        end
    end

    // high-high product lands beyond the word and drops out
    assign prod = DATA_WIDTH'(ll_reg) + ((x1_reg + x2_reg) << HL);
endmodule

@@ sv/iaw_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider on magnitudes, one quotient bit per stage
module iaw_div #(
    parameter int DATA_WIDTH = iaw_pkg::DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic [DATA_WIDTH-1:0] quot
);
    localparam int N = DATA_WIDTH;
    logic [N-1:0] ua, ub;
    logic [N-1:0] rem_reg [N+1];
    logic [N-1:0] num_reg [N+1];
    logic [N-1:0] den_reg [N+1];
    logic         neg_reg [N+1];
    logic [N-1:0] rem_next [N];
    logic [N-1:0] num_next [N];
    logic [N:0]   trial [N];

    assign ua = a[N-1] ? (~a + N'(1)) : a;
    assign ub = b[N-1] ? (~b + N'(1)) : b;

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= '0;
            num_reg[0] <= ua;
            den_reg[0] <= ub;
            neg_reg[0] <= a[N-1] ^ b[N-1];
        end
    end

    // num shifts left; vacated low bits collect quotient bits
    for (genvar i = 0; i < N; i++) begin : g_st
        always_comb begin
            trial[i] = {rem_reg[i], num_reg[i][N-1]} - {1'b0, den_reg[i]};
            if (trial[i][N]) begin
                rem_next[i] = {rem_reg[i][N-2:0], num_reg[i][N-1]};
                num_next[i] = {num_reg[i][N-2:0], 1'b0};
            end else begin
                rem_next[i] = trial[i][N-1:0];
                num_next[i] = {num_reg[i][N-2:0], 1'b1};
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[i+1] <= rem_next[i];
                num_reg[i+1] <= num_next[i];
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    logic unused_rst;
    assign unused_rst = aresetn;
    assign quot = neg_reg[N] ? (~num_reg[N] + N'(1)) : num_reg[N];
endmodule

@@ bench/integer_alu_with_warnings_core_tb.sv @@
`timescale 1ns / 1ps
module integer_alu_with_warnings_core_tb;

    localparam int DW = 32;
    localparam int SW = ((2*DW+5+7)/8)*8;
    localparam int MW = ((DW+3+7)/8)*8;
    localparam int N_RANDOM = 1800;
    localparam int N_QUIET = 200;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic [iaw_pkg::FUNC_W-1:0] func;
        logic [DW-1:0]              a;
        logic [DW-1:0]              b;
    } alu_op_t;

    typedef struct packed {
        logic [DW-1:0]                result;
        logic [iaw_pkg::STATUS_W-1:0] status;
    } alu_res_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [MW-1:0] m_tdata;
    logic          s_tready_q = 1'b0;

    alu_op_t  op_queue[$];
    alu_res_t expected_results[$];
    int       errors = 0;
    bit       hold_sender = 0;
    bit       hold_receiver = 0;
    bit       quiet = 0;
    int       send_gap = 0;
    int       recv_gap = 0;
    int       hold_count = 0;

    integer_alu_with_warnings_core #(.DATA_WIDTH(DW)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic alu_res_t alu_compute(alu_op_t op);
        alu_res_t r;
        logic signed [DW-1:0] sa;
        logic signed [DW-1:0] sb;
        logic [DW-1:0] ua;
        logic [DW-1:0] ub;
        logic [DW-1:0] q;
        logic [iaw_pkg::SHIFT_W-1:0] amt;
        sa = op.a;
        sb = op.b;
        r.result = '0;
        r.status = iaw_pkg::ST_OK;
        amt = op.b[iaw_pkg::SHIFT_W-1:0];
        case (op.func)
            iaw_pkg::FN_ADD:  r.result = op.a + op.b;
            iaw_pkg::FN_AND:  r.result = op.a & op.b;
            iaw_pkg::FN_LAND: r.result = (op.a != 0 && op.b != 0) ? 1 : 0;
            iaw_pkg::FN_OR:   r.result = op.a | op.b;
            iaw_pkg::FN_LOR:  r.result = (op.a != 0 || op.b != 0) ? 1 : 0;
            iaw_pkg::FN_XOR:  r.result = op.a ^ op.b;
            iaw_pkg::FN_SUB:  r.result = op.a - op.b;
            iaw_pkg::FN_MUL:  r.result = op.a * op.b;
            iaw_pkg::FN_SHL, iaw_pkg::FN_SAR: begin
                // unsigned compare catches negative amounts too
                if (op.b >= iaw_pkg::SHIFT_LIMIT) r.status = iaw_pkg::ST_SHIFT;
                if (op.func == iaw_pkg::FN_SHL) r.result = op.a << amt;
                else r.result = sa >>> amt;
            end
            iaw_pkg::FN_DIV: begin
                if (op.b == 0) begin
                    r.status = iaw_pkg::ST_DIVZERO;
                    r.result = {1'b0, {(DW-1){1'b1}}};
                end else if (op.a == {1'b1, {(DW-1){1'b0}}} && op.b == '1) begin
                    r.status = iaw_pkg::ST_OVERFLOW;
                    r.result = op.a;
                end else begin
                    ua = sa[DW-1] ? -op.a : op.a;
                    ub = sb[DW-1] ? -op.b : op.b;
                    q = ua / ub;
                    r.result = (sa[DW-1] != sb[DW-1]) ? -q : q;
                end
            end
            iaw_pkg::FN_LT: r.result = (sa < sb) ? 1 : 0;
            iaw_pkg::FN_GT: r.result = (sa > sb) ? 1 : 0;
            iaw_pkg::FN_EQ: r.result = (sa == sb) ? 1 : 0;
            iaw_pkg::FN_NE: r.result = (sa != sb) ? 1 : 0;
            iaw_pkg::FN_LE: r.result = (sa <= sb) ? 1 : 0;
            iaw_pkg::FN_GE: r.result = (sa >= sb) ? 1 : 0;
            default: begin
                r.result = '0;
                r.status = iaw_pkg::ST_INVALID;
            end
        endcase
        return r;
    endfunction

    function automatic logic [DW-1:0] pick_operand();
        logic [DW-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = {1'b1, {(DW-1){1'b0}}};
            3: v = {1'b0, {(DW-1){1'b1}}};
            4: v = $urandom_range(0, 40);
            5: v = -$urandom_range(1, 40);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic alu_op_t make_op(logic [iaw_pkg::FUNC_W-1:0] f, logic [DW-1:0] a,
                                        logic [DW-1:0] b);
        alu_op_t op;
        op.func = f;
        op.a = a;
        op.b = b;
        return op;
    endfunction

    // sender: drive at the falling edge, advance on accept
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else begin
            if (s_tvalid && s_tready_q)
                op_queue.pop_front();
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            if (op_queue.size() == 0 || hold_sender || send_gap > 0) begin
                s_tvalid <= 1'b0;
            end else if (!quiet && !(s_tvalid && !s_tready_q) && $urandom_range(0, 9) == 0) begin
                s_tvalid <= 1'b0;
                send_gap <= $urandom_range(0, 4);
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= {{(SW-2*DW-5){1'b0}}, op_queue[0].b, op_queue[0].a,
                            op_queue[0].func};
            end
        end
    end

    // capture the handshake at the rising edge
    always @(posedge aclk) begin
        s_tready_q <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            expected_results.push_back(alu_compute(make_op(s_tdata[iaw_pkg::FUNC_W-1:0],
                s_tdata[DW+4:5], s_tdata[2*DW+4:DW+5])));
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_receiver && hold_count < HOLD_CYCLES) begin
            m_tready <= 1'b0;
            hold_count <= hold_count + 1;
        end else if (recv_gap > 0) begin
            m_tready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            recv_gap <= $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each delivered word with the oldest prediction
    always @(posedge aclk) begin
        alu_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[DW-1:0] !== want.result) begin
                    $error("result: expected %h actual %h", want.result, m_tdata[DW-1:0]);
                    errors++;
                end
                if (m_tdata[DW+2:DW] !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status,
                           m_tdata[DW+2:DW]);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [DW-1:0] mn;
        logic [DW-1:0] mx;
        int i;
        mn = {1'b1, {(DW-1){1'b0}}};
        mx = {1'b0, {(DW-1){1'b1}}};
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: every operation at the extremes, plus shift, divide and invalid-code cases
        for (int f = 0; f <= 16; f++)
            op_queue.push_back(make_op(iaw_pkg::FUNC_W'(f), mx, mn));
        op_queue.push_back(make_op(iaw_pkg::FN_SHL, '1, 32));
        op_queue.push_back(make_op(iaw_pkg::FN_SAR, mn, '1));
        op_queue.push_back(make_op(iaw_pkg::FN_SAR, mn, 31));
        op_queue.push_back(make_op(iaw_pkg::FN_DIV, mn, 0));
        op_queue.push_back(make_op(iaw_pkg::FN_DIV, mn, '1));
        op_queue.push_back(make_op(iaw_pkg::FN_DIV, -7, 2));
        op_queue.push_back(make_op(iaw_pkg::FUNC_W'(17), '1, '1));
        op_queue.push_back(make_op(iaw_pkg::FUNC_W'(31), 0, 0));

        // long receiver hold-off while the sender keeps offering
        hold_receiver = 1'b1;
        for (i = 0; i < 100; i++)
            op_queue.push_back(make_op(iaw_pkg::FUNC_W'($urandom_range(0, 31)),
                                       pick_operand(), pick_operand()));
        wait (hold_count == HOLD_CYCLES);
        hold_receiver = 1'b0;

        for (i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                // sender pause until everything has drained
                while (op_queue.size() != 0) @(posedge aclk);
                hold_sender = 1'b1;
                while (expected_results.size() != 0) @(posedge aclk);
                hold_sender = 1'b0;
            end
            if (i == N_RANDOM - N_QUIET) begin
                while (op_queue.size() != 0) @(posedge aclk);
                quiet = 1'b1;
            end
            op_queue.push_back(make_op(iaw_pkg::FUNC_W'(($urandom_range(0, 9) == 0)
                                           ? $urandom_range(17, 31)
                                           : $urandom_range(0, 16)),
                                       pick_operand(), pick_operand()));
        end

        while (op_queue.size() != 0) @(posedge aclk);
        i = 0;
        while (expected_results.size() != 0 && i < 100000) begin
            @(posedge aclk);
            i++;
        end
        repeat (40) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
